FILE: rtl/core/se2pg_pkg.sv
// se2pg_pkg: shared types and constants of the se2 pose graph edge cost block
// opcodes, controller states, command struct, cordic constants and arctangent table
// no dependencies
`timescale 1ns / 1ps

package se2pg_pkg;

  typedef enum logic [1:0] {
    OP_POSE  = 2'd0,
    OP_EDGE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CORDIC,
    ST_CFIX,
    ST_ROT,
    ST_ERR,
    ST_ET,
    ST_QUAD,
    ST_EDGE,
    ST_TOTAL,
    ST_DONE
  } state_e;

  // one command word per cycle from the controller to the datapath
  typedef struct packed {
    logic       capture;
    logic       diff;
    logic       cordic_step;
    logic       cordic_fix;
    logic       rot;
    logic       err;
    logic       et;
    logic       quad;
    logic       edge_fin;
    logic       total;
    logic [4:0] idx;
  } cmd_t;

  localparam int CNT_W  = 5;
  localparam int ERR_W  = 36;
  localparam int ET_W   = 20;
  localparam int ACC_W  = 112;
  localparam int MULA_W = 37;
  localparam int MULB_W = 36;
  localparam int PROD_W = MULA_W + MULB_W;
  localparam int QUAD_LAST = 23;
  localparam int ROT_LAST  = 4;

  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032875;
  localparam logic [31:0]        PI_Q29   = 32'd1686629713;

  localparam logic signed [63:0] COST_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] COST_MIN = 64'sh8000_0000_0000_0000;

  function automatic logic [31:0] atan_lut(input logic [4:0] k);
    logic [31:0] r;
    case (k)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/se2pg_ctrl.sv
// se2pg_ctrl: sequencer of the edge cost block
// walks difference, cordic, rotation, error, quadratic form, edge and total phases; uses se2pg_pkg
`timescale 1ns / 1ps

module se2pg_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [1:0]      opcode_i,
  output logic            busy_o,
  output logic            done_o,
  output se2pg_pkg::cmd_t cmd_o
);

  se2pg_pkg::state_e state_q, state_d;
  logic [se2pg_pkg::CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= se2pg_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o     = '0;
    cmd_o.idx = cnt_q;
    case (state_q)
      se2pg_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          cnt_d         = '0;
          if (opcode_i == se2pg_pkg::OP_EDGE) state_d = se2pg_pkg::ST_DIFF;
          else state_d = se2pg_pkg::ST_DONE;
        end
      end
      se2pg_pkg::ST_DIFF: begin
        cmd_o.diff = 1'b1;
        cnt_d      = '0;
        state_d    = se2pg_pkg::ST_CORDIC;
      end
      se2pg_pkg::ST_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
        if (cnt_q == se2pg_pkg::CNT_W'(CORDIC_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = se2pg_pkg::ST_CFIX;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      se2pg_pkg::ST_CFIX: begin
        cmd_o.cordic_fix = 1'b1;
        cnt_d            = '0;
        state_d          = se2pg_pkg::ST_ROT;
      end
      se2pg_pkg::ST_ROT: begin
        cmd_o.rot = 1'b1;
        if (cnt_q == se2pg_pkg::CNT_W'(se2pg_pkg::ROT_LAST)) begin
          cnt_d   = '0;
          state_d = se2pg_pkg::ST_ERR;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      se2pg_pkg::ST_ERR: begin
        cmd_o.err = 1'b1;
        state_d   = se2pg_pkg::ST_ET;
      end
      se2pg_pkg::ST_ET: begin
        cmd_o.et = 1'b1;
        cnt_d    = '0;
        state_d  = se2pg_pkg::ST_QUAD;
      end
      se2pg_pkg::ST_QUAD: begin
        cmd_o.quad = 1'b1;
        if (cnt_q == se2pg_pkg::CNT_W'(se2pg_pkg::QUAD_LAST)) begin
          cnt_d   = '0;
          state_d = se2pg_pkg::ST_EDGE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      se2pg_pkg::ST_EDGE: begin
        cmd_o.edge_fin = 1'b1;
        state_d        = se2pg_pkg::ST_TOTAL;
      end
      se2pg_pkg::ST_TOTAL: begin
        cmd_o.total = 1'b1;
        state_d     = se2pg_pkg::ST_DONE;
      end
      se2pg_pkg::ST_DONE: begin
        state_d = se2pg_pkg::ST_IDLE;
      end
      default: begin
        state_d = se2pg_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != se2pg_pkg::ST_IDLE);
  assign done_o = (state_q == se2pg_pkg::ST_DONE);

endmodule

FILE: rtl/core/se2pg_dp.sv
// se2pg_dp: datapath of the edge cost block
// pose memories, cordic, one shared multiplier, accumulator and saturation; uses se2pg_pkg
`timescale 1ns / 1ps

module se2pg_dp #(
  parameter int POSE_COUNT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  se2pg_pkg::cmd_t     cmd_i,
  input  logic [1:0]          opcode_i,
  input  logic [9:0]          from_index_i,
  input  logic [9:0]          to_index_i,
  input  logic signed [31:0]  val_x_i,
  input  logic signed [31:0]  val_y_i,
  input  logic signed [15:0]  val_angle_i,
  input  logic signed [31:0]  info_xx_i,
  input  logic signed [31:0]  info_xy_i,
  input  logic signed [31:0]  info_xt_i,
  input  logic signed [31:0]  info_yy_i,
  input  logic signed [31:0]  info_yt_i,
  input  logic signed [31:0]  info_tt_i,
  output logic signed [63:0]  edge_cost_o,
  output logic signed [63:0]  total_cost_o,
  output logic                saturated_o
);

  localparam int AW = (POSE_COUNT > 1) ? $clog2(POSE_COUNT) : 1;
  localparam int EW = se2pg_pkg::ERR_W;
  localparam int TW = se2pg_pkg::ET_W;
  localparam int AC = se2pg_pkg::ACC_W;

  // pose memories, two read ports and one write port
  logic signed [31:0] mem_x [POSE_COUNT];
  logic signed [31:0] mem_y [POSE_COUNT];
  logic signed [15:0] mem_a [POSE_COUNT];

  logic [AW-1:0] addr_a, addr_b;
  logic          ok_a, ok_b, ok_a_q, ok_b_q;
  logic signed [31:0] rx_a_q, ry_a_q, rx_b_q, ry_b_q;
  logic signed [15:0] ra_a_q, ra_b_q;

  assign addr_a = AW'(from_index_i);
  assign addr_b = AW'(to_index_i);
  assign ok_a   = ({22'd0, from_index_i} < 32'(POSE_COUNT));
  assign ok_b   = ({22'd0, to_index_i} < 32'(POSE_COUNT));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && opcode_i == se2pg_pkg::OP_POSE && ok_a) begin
      mem_x[addr_a] <= val_x_i;
      mem_y[addr_a] <= val_y_i;
      mem_a[addr_a] <= val_angle_i;
    end
    if (cmd_i.capture) begin
      rx_a_q <= mem_x[addr_a];
      ry_a_q <= mem_y[addr_a];
      ra_a_q <= mem_a[addr_a];
      rx_b_q <= mem_x[addr_b];
      ry_b_q <= mem_y[addr_b];
      ra_b_q <= mem_a[addr_b];
    end
  end

  // latched item fields
  logic signed [31:0] vx_q, vy_q, ixx_q, ixy_q, ixt_q, iyy_q, iyt_q, itt_q;
  logic signed [15:0] va_q, aa_q, ba_q;
  logic signed [32:0] gx_q, gy_q;
  logic signed [32:0] z_q;
  logic signed [33:0] cx_q, cy_q;
  logic               flip_q;
  logic signed [69:0] accx_q, accy_q;
  logic signed [EW-1:0] ex_q, ey_q;
  logic signed [TW-1:0] et_q;
  logic signed [35:0] uvh_q;
  logic signed [AC-1:0] acc_q;
  logic signed [63:0] edge_q, total_q;
  logic               sat_q;
  logic signed [se2pg_pkg::PROD_W-1:0] prod_q;

  // combinational helpers
  logic signed [31:0] ax, ay, bx, by;
  logic signed [15:0] aa, ba;
  logic signed [32:0] z0;
  logic signed [33:0] tx, ty;
  logic signed [32:0] atan_v;
  logic [15:0]        wdiff;
  logic signed [16:0] wr;
  logic signed [69:0] px, py;
  logic signed [se2pg_pkg::MULA_W-1:0] mul_a;
  logic signed [se2pg_pkg::MULB_W-1:0] mul_b;
  logic [2:0]         term;
  logic [1:0]         phase;
  logic signed [EW-1:0] qu, qv;
  logic signed [31:0] qw;
  logic               qdbl;
  logic signed [AC-1:0] addend;
  logic signed [AC-1:0] sh;
  logic               fits;
  logic signed [64:0] tsum;

  assign ax = ok_a_q ? rx_a_q : 32'sd0;
  assign ay = ok_a_q ? ry_a_q : 32'sd0;
  assign aa = ok_a_q ? ra_a_q : 16'sd0;
  assign bx = ok_b_q ? rx_b_q : 32'sd0;
  assign by = ok_b_q ? ry_b_q : 32'sd0;
  assign ba = ok_b_q ? ra_b_q : 16'sd0;

  assign z0     = 33'(signed'({aa, 16'h0000}));
  assign tx     = cy_q >>> cmd_i.idx;
  assign ty     = cx_q >>> cmd_i.idx;
  assign atan_v = 33'(se2pg_pkg::atan_lut(cmd_i.idx));

  // angle error in binary units, wrapped; exactly pi counts as plus pi
  assign wdiff = 16'(va_q - ba_q + aa_q);
  assign wr    = (wdiff == 16'h8000) ? 17'sd32768 : 17'(signed'(wdiff));

  assign px = (accx_q + 70'sd536870912) >>> 30;
  assign py = (accy_q + 70'sd536870912) >>> 30;

  assign term  = cmd_i.idx[4:2];
  assign phase = cmd_i.idx[1:0];

  always_comb begin
    case (term)
      3'd0:    begin qu = ex_q;     qv = ex_q;     qw = ixx_q; qdbl = 1'b0; end
      3'd1:    begin qu = ey_q;     qv = ey_q;     qw = iyy_q; qdbl = 1'b0; end
      3'd2:    begin qu = EW'(et_q); qv = EW'(et_q); qw = itt_q; qdbl = 1'b0; end
      3'd3:    begin qu = ex_q;     qv = ey_q;     qw = ixy_q; qdbl = 1'b1; end
      3'd4:    begin qu = ex_q;     qv = EW'(et_q); qw = ixt_q; qdbl = 1'b1; end
      3'd5:    begin qu = ey_q;     qv = EW'(et_q); qw = iyt_q; qdbl = 1'b1; end
      default: begin qu = '0;       qv = '0;       qw = '0;    qdbl = 1'b0; end
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.rot) begin
      case (cmd_i.idx)
        5'd0:    begin mul_a = 37'(cx_q); mul_b = 36'(gx_q); end
        5'd1:    begin mul_a = 37'(cy_q); mul_b = 36'(gy_q); end
        5'd2:    begin mul_a = 37'(cx_q); mul_b = 36'(gy_q); end
        5'd3:    begin mul_a = 37'(cy_q); mul_b = 36'(gx_q); end
        default: begin mul_a = '0;        mul_b = '0;        end
      endcase
    end else if (cmd_i.err) begin
      mul_a = 37'(wr);
      mul_b = 36'(signed'({1'b0, se2pg_pkg::PI_Q29}));
    end else if (cmd_i.quad) begin
      case (phase)
        2'd0:    begin mul_a = 37'(qu); mul_b = 36'(qv); end
        2'd1:    begin mul_a = signed'({1'b0, prod_q[35:0]}); mul_b = 36'(qw); end
        2'd2:    begin mul_a = 37'(uvh_q); mul_b = 36'(qw); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_comb begin
    addend = AC'(prod_q);
    if (phase == 2'd3) addend = addend <<< 36;
    if (qdbl) addend = addend <<< 1;
  end

  // half of the quadratic form, q64.48 down to q32.32
  assign sh   = acc_q >>> 17;
  assign fits = (acc_q[AC-1:80] == {(AC - 80){acc_q[80]}});
  assign tsum = 65'(edge_q) + 65'(total_q);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.capture) begin
      vx_q   <= val_x_i;
      vy_q   <= val_y_i;
      va_q   <= val_angle_i;
      ixx_q  <= info_xx_i;
      ixy_q  <= info_xy_i;
      ixt_q  <= info_xt_i;
      iyy_q  <= info_yy_i;
      iyt_q  <= info_yt_i;
      itt_q  <= info_tt_i;
      ok_a_q <= ok_a;
      ok_b_q <= ok_b;
      edge_q <= '0;
      sat_q  <= 1'b0;
    end
    if (cmd_i.diff) begin
      gx_q <= 33'(bx) - 33'(ax);
      gy_q <= 33'(by) - 33'(ay);
      aa_q <= aa;
      ba_q <= ba;
      cx_q <= se2pg_pkg::GAIN_Q30;
      cy_q <= '0;
      if (z0 >= 33'sd1073741824) begin
        z_q    <= z0 - 33'sd2147483648;
        flip_q <= 1'b1;
      end else if (z0 < -33'sd1073741824) begin
        z_q    <= z0 + 33'sd2147483648;
        flip_q <= 1'b1;
      end else begin
        z_q    <= z0;
        flip_q <= 1'b0;
      end
    end
    if (cmd_i.cordic_step) begin
      if (!z_q[32]) begin
        cx_q <= cx_q - tx;
        cy_q <= cy_q + ty;
        z_q  <= z_q - atan_v;
      end else begin
        cx_q <= cx_q + tx;
        cy_q <= cy_q - ty;
        z_q  <= z_q + atan_v;
      end
    end
    if (cmd_i.cordic_fix && flip_q) begin
      cx_q <= -cx_q;
      cy_q <= -cy_q;
    end
    if (cmd_i.rot) begin
      case (cmd_i.idx)
        5'd1:    accx_q <= 70'(prod_q);
        5'd2:    accx_q <= accx_q + 70'(prod_q);
        5'd3:    accy_q <= 70'(prod_q);
        5'd4:    accy_q <= accy_q - 70'(prod_q);
        default: accy_q <= accy_q;
      endcase
    end
    if (cmd_i.err) begin
      ex_q <= EW'(70'(vx_q) - px);
      ey_q <= EW'(70'(vy_q) - py);
    end
    if (cmd_i.et) begin
      et_q  <= TW'((prod_q + 73'sd134217728) >>> 28);
      acc_q <= '0;
    end
    if (cmd_i.quad) begin
      if (phase == 2'd1) uvh_q <= prod_q[71:36];
      if (phase == 2'd2 || phase == 2'd3) acc_q <= acc_q + addend;
    end
    if (cmd_i.edge_fin) begin
      if (fits) begin
        edge_q <= sh[63:0];
      end else begin
        edge_q <= acc_q[AC-1] ? se2pg_pkg::COST_MIN : se2pg_pkg::COST_MAX;
        sat_q  <= 1'b1;
      end
    end
    if (cmd_i.total && tsum[64] != tsum[63]) sat_q <= 1'b1;
  end

  // running total, the only payload with a defined reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cmd_i.capture && opcode_i == se2pg_pkg::OP_CLEAR) begin
      total_q <= '0;
    end else if (cmd_i.total) begin
      if (tsum[64] != tsum[63]) begin
        total_q <= edge_q[63] ? se2pg_pkg::COST_MIN : se2pg_pkg::COST_MAX;
      end else begin
        total_q <= tsum[63:0];
      end
    end
  end

  assign edge_cost_o  = edge_q;
  assign total_cost_o = total_q;
  assign saturated_o  = sat_q;

endmodule

FILE: rtl/core/se2pg_ctrl_unused_guard.sv
// se2pg_ctrl_unused_guard: result strobe and busy flag between controller and top level ports
// passes busy through and gates the strobe to an active command; no dependencies
`timescale 1ns / 1ps

module se2pg_ctrl_unused_guard (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic busy_i,
  input  logic done_i,
  output logic busy_o,
  output logic done_o
);

  logic seen_q;

  // remembers an active command so a strobe never leaves without one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= busy_i && !done_i;
    end
  end

  assign busy_o = busy_i;
  assign done_o = done_i && (seen_q || busy_i);

endmodule

FILE: rtl/core/se2_pose_graph_edge_cost.sv
// se2_pose_graph_edge_cost: top level of the se2 pose graph edge cost block
// instantiates se2pg_ctrl, se2pg_dp and se2pg_ctrl_unused_guard; uses se2pg_pkg
//
// channel   direction  ports                                        handshake
// command   in         opcode_i, from/to_index_i, val_*_i, info_*_i start_i high, busy_o low
// result    out        edge_cost_o, total_cost_o, saturated_o       done_o for one cycle
//
// pose write, clear and opcode 3 raise done_o in the first cycle after the accepting edge
// an edge raises done_o after the cordic loop, 5 rotation and 24 quadratic form passes
// through the one shared multiplier, and the edge and total updates
// busy_o stays high from the cycle after accept through the done_o cycle
// the result side never stalls; results are taken in the done_o cycle
// reset clears the controller and the running total; pose memories are not cleared
`timescale 1ns / 1ps

module se2_pose_graph_edge_cost #(
  parameter int POSE_COUNT   = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         opcode_i,
  input  logic [9:0]         from_index_i,
  input  logic [9:0]         to_index_i,
  input  logic signed [31:0] val_x_i,
  input  logic signed [31:0] val_y_i,
  input  logic signed [15:0] val_angle_i,
  input  logic signed [31:0] info_xx_i,
  input  logic signed [31:0] info_xy_i,
  input  logic signed [31:0] info_xt_i,
  input  logic signed [31:0] info_yy_i,
  input  logic signed [31:0] info_yt_i,
  input  logic signed [31:0] info_tt_i,
  output logic               done_o,
  output logic signed [63:0] edge_cost_o,
  output logic signed [63:0] total_cost_o,
  output logic               saturated_o
);

  se2pg_pkg::cmd_t cmd;
  logic            ctrl_busy;
  logic            ctrl_done;

  se2pg_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .opcode_i(opcode_i),
    .busy_o  (ctrl_busy),
    .done_o  (ctrl_done),
    .cmd_o   (cmd)
  );

  se2pg_ctrl_unused_guard u_guard (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .busy_i(ctrl_busy),
    .done_i(ctrl_done),
    .busy_o(busy_o),
    .done_o(done_o)
  );

  se2pg_dp #(
    .POSE_COUNT(POSE_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .opcode_i    (opcode_i),
    .from_index_i(from_index_i),
    .to_index_i  (to_index_i),
    .val_x_i     (val_x_i),
    .val_y_i     (val_y_i),
    .val_angle_i (val_angle_i),
    .info_xx_i   (info_xx_i),
    .info_xy_i   (info_xy_i),
    .info_xt_i   (info_xt_i),
    .info_yy_i   (info_yy_i),
    .info_yt_i   (info_yt_i),
    .info_tt_i   (info_tt_i),
    .edge_cost_o (edge_cost_o),
    .total_cost_o(total_cost_o),
    .saturated_o (saturated_o)
  );

  // a result only leaves while a transfer is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy_o)
    else $error("result strobe outside a busy window");

  // an accepted command always makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i && !busy_o |=> busy_o)
    else $error("accepted command did not start");

  // a saturation flag comes with a value at a limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturated_o |->
      (edge_cost_o == se2pg_pkg::COST_MAX || edge_cost_o == se2pg_pkg::COST_MIN ||
       total_cost_o == se2pg_pkg::COST_MAX || total_cost_o == se2pg_pkg::COST_MIN))
    else $error("saturation flag without a limit value");

endmodule

FILE: test/se2_pose_graph_edge_cost_test.sv
// se2_pose_graph_edge_cost_test: self-checking testbench of the se2 pose graph edge cost block
// a directed command table, then random pose writes, edges, clears and opcode 3 commands against a local predictor
// depends on se2pg_pkg and se2_pose_graph_edge_cost
`timescale 1ns / 1ps

module se2_pose_graph_edge_cost_test;

  localparam int NUM_RANDOM = 1250;
  localparam int CALM_TAIL  = 150;

  typedef struct {
    se2pg_pkg::op_e     op;
    logic [9:0]         from_idx;
    logic [9:0]         to_idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] ang;
    logic signed [31:0] ixx, ixy, ixt, iyy, iyt, itt;
    bit                 typed;
    logic signed [63:0] edge_cost;
    logic signed [63:0] total_cost;
    bit                 sat;
  } command_t;

  typedef struct {
    logic signed [63:0] edge_cost;
    logic signed [63:0] total_cost;
    bit                 sat;
  } cost_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         opcode_i = '0;
  logic [9:0]         from_index_i = '0;
  logic [9:0]         to_index_i = '0;
  logic signed [31:0] val_x_i = '0;
  logic signed [31:0] val_y_i = '0;
  logic signed [15:0] val_angle_i = '0;
  logic signed [31:0] info_xx_i = '0, info_xy_i = '0, info_xt_i = '0;
  logic signed [31:0] info_yy_i = '0, info_yt_i = '0, info_tt_i = '0;
  logic               done_o;
  logic signed [63:0] edge_cost_o;
  logic signed [63:0] total_cost_o;
  logic               saturated_o;

  se2_pose_graph_edge_cost i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .from_index_i, .to_index_i,
    .val_x_i, .val_y_i, .val_angle_i, .info_xx_i, .info_xy_i, .info_xt_i,
    .info_yy_i, .info_yt_i, .info_tt_i, .done_o, .edge_cost_o, .total_cost_o,
    .saturated_o
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic signed [31:0] pose_x [1024];
  logic signed [31:0] pose_y [1024];
  logic signed [15:0] pose_ang [1024];
  bit                 pose_valid [1024];
  int                 valid_poses [$];
  logic signed [63:0] running_total;

  cost_t    pending_costs [$];
  command_t directed [$];
  int       fail_count = 0;

  localparam longint ARCTAN [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  function automatic void queue_cost(cost_t r);
    pending_costs.insert(pending_costs.size(), r);
  endfunction

  function automatic void add_row(command_t c);
    directed.insert(directed.size(), c);
  endfunction

  function automatic cost_t eval_command(command_t c);
    cost_t              r;
    longint             z, cx, sy, dx, dy;
    bit                 flip;
    logic signed [127:0] cs, sn, gx, gy, px, py, ex, ey, et, wr, acc, sh;
    logic signed [64:0] sum;
    r.edge_cost = '0;
    r.sat = 1'b0;
    case (c.op)
      se2pg_pkg::OP_POSE: begin
        pose_x[c.from_idx] = c.x;
        pose_y[c.from_idx] = c.y;
        pose_ang[c.from_idx] = c.ang;
        if (!pose_valid[c.from_idx])
          valid_poses.insert(valid_poses.size(), int'(c.from_idx));
        pose_valid[c.from_idx] = 1'b1;
      end
      se2pg_pkg::OP_CLEAR: running_total = '0;
      se2pg_pkg::OP_EDGE: begin
        z = longint'(pose_ang[c.from_idx]) * 65536;
        cx = se2pg_pkg::GAIN_Q30;
        sy = 0;
        flip = 0;
        if (z >= (64'sd1 << 30)) begin
          z -= 64'sd1 << 31; flip = 1;
        end else if (z < -(64'sd1 << 30)) begin
          z += 64'sd1 << 31; flip = 1;
        end
        for (int k = 0; k < 16; k++) begin
          dx = sy >>> k;
          dy = cx >>> k;
          if (z >= 0) begin
            cx -= dx; sy += dy; z -= ARCTAN[k];
          end else begin
            cx += dx; sy -= dy; z += ARCTAN[k];
          end
        end
        if (flip) begin
          cx = -cx; sy = -sy;
        end
        cs = cx;
        sn = sy;
        gx = 128'(pose_x[c.to_idx]) - 128'(pose_x[c.from_idx]);
        gy = 128'(pose_y[c.to_idx]) - 128'(pose_y[c.from_idx]);
        px = (cs * gx + sn * gy + (128'sd1 <<< 29)) >>> 30;
        py = (cs * gy - sn * gx + (128'sd1 <<< 29)) >>> 30;
        ex = 128'(c.x) - px;
        ey = 128'(c.y) - py;
        // heading error wrapped to (-pi, pi]
        wr = 128'(16'(c.ang - pose_ang[c.to_idx] + pose_ang[c.from_idx]));
        if (wr == -128'sd32768) wr = 128'sd32768;
        et = (wr * $signed(128'(se2pg_pkg::PI_Q29)) + (128'sd1 <<< 27)) >>> 28;
        acc = ex * ex * 128'(c.ixx) + ey * ey * 128'(c.iyy) + et * et * 128'(c.itt)
            + 2 * (ex * ey * 128'(c.ixy) + ex * et * 128'(c.ixt) + ey * et * 128'(c.iyt));
        sh = acc >>> 17;
        if (sh[127:63] == '0 || sh[127:63] == '1) begin
          r.edge_cost = sh[63:0];
        end else begin
          r.sat = 1'b1;
          r.edge_cost = acc < 0 ? se2pg_pkg::COST_MIN : se2pg_pkg::COST_MAX;
        end
        sum = 65'(running_total) + 65'(r.edge_cost);
        if (sum > 65'(se2pg_pkg::COST_MAX)) begin
          running_total = se2pg_pkg::COST_MAX; r.sat = 1'b1;
        end else if (sum < 65'(se2pg_pkg::COST_MIN)) begin
          running_total = se2pg_pkg::COST_MIN; r.sat = 1'b1;
        end else begin
          running_total = sum[63:0];
        end
      end
      default: ;
    endcase
    r.total_cost = running_total;
    return r;
  endfunction

  // one command transfer; start stays high when the next command follows at once
  task automatic issue(command_t c);
    cost_t r;
    @(negedge clk_i);
    start_i = 1'b1;
    opcode_i = c.op;
    from_index_i = c.from_idx;
    to_index_i = c.to_idx;
    val_x_i = c.x;
    val_y_i = c.y;
    val_angle_i = c.ang;
    info_xx_i = c.ixx; info_xy_i = c.ixy; info_xt_i = c.ixt;
    info_yy_i = c.iyy; info_yt_i = c.iyt; info_tt_i = c.itt;
    do @(posedge clk_i); while (busy_o);
    r = eval_command(c);
    if (c.typed) begin
      r.edge_cost = c.edge_cost;
      r.total_cost = c.total_cost;
      r.sat = c.sat;
    end
    queue_cost(r);
  endtask

  task automatic hold_off(int cycles);
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cost_t e;
    if (rst_ni && done_o) begin
      if (pending_costs.size() == 0) begin
        $display("%0t: result with nothing expected: edge %h total %h sat %b", $time,
                 edge_cost_o, total_cost_o, saturated_o);
        fail_count++;
      end else begin
        e = pending_costs.pop_front();
        if (edge_cost_o !== e.edge_cost) begin
          $display("%0t: edge_cost expected %h actual %h", $time, e.edge_cost, edge_cost_o);
          fail_count++;
        end
        if (total_cost_o !== e.total_cost) begin
          $display("%0t: total_cost expected %h actual %h", $time, e.total_cost,
                   total_cost_o);
          fail_count++;
        end
        if (saturated_o !== e.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, e.sat, saturated_o);
          fail_count++;
        end
      end
    end
  end

  function automatic command_t make_cmd(se2pg_pkg::op_e op, int fi, int ti, int x, int y,
                                        int a, int ixx, int ixy, int ixt, int iyy, int iyt,
                                        int itt);
    command_t c;
    c.op = op; c.from_idx = 10'(fi); c.to_idx = 10'(ti);
    c.x = x; c.y = y; c.ang = 16'(a);
    c.ixx = ixx; c.ixy = ixy; c.ixt = ixt; c.iyy = iyy; c.iyt = iyt; c.itt = itt;
    c.typed = 0; c.edge_cost = '0; c.total_cost = '0; c.sat = 0;
    return c;
  endfunction

  function automatic command_t with_result(command_t c, longint ec, longint tc, bit s);
    c.typed = 1; c.edge_cost = ec; c.total_cost = tc; c.sat = s;
    return c;
  endfunction

  function automatic int signed_span(int bits);
    return int'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1));
  endfunction

  function automatic command_t random_cmd();
    command_t c;
    int       pick;
    bit       wide;
    c = make_cmd(se2pg_pkg::OP_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
    pick = $urandom_range(0, 99);
    wide = $urandom_range(0, 6) == 0;
    if (pick < 30 || valid_poses.size() == 0) begin
      c.op = se2pg_pkg::OP_POSE;
      if ($urandom_range(0, 1)) c.from_idx = 10'($urandom_range(0, 15));
      if (!wide) begin
        c.x = signed_span(22);
        c.y = signed_span(22);
      end
    end else if (pick < 90) begin
      c.op = se2pg_pkg::OP_EDGE;
      c.from_idx = 10'(valid_poses[$urandom_range(0, valid_poses.size() - 1)]);
      c.to_idx = 10'(valid_poses[$urandom_range(0, valid_poses.size() - 1)]);
      if (!wide) begin
        c.x = signed_span(22);
        c.y = signed_span(22);
        c.ixx = $urandom_range(0, 1 << 18);
        c.iyy = $urandom_range(0, 1 << 18);
        c.itt = $urandom_range(0, 1 << 18);
        c.ixy = signed_span(14);
        c.ixt = signed_span(14);
        c.iyt = signed_span(14);
      end
    end else if (pick < 95) begin
      c.op = se2pg_pkg::OP_CLEAR;
    end
    return c;
  endfunction

  initial begin
    add_row(with_result(make_cmd(se2pg_pkg::OP_POSE, 0, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                        0, 0, 0));
    add_row(make_cmd(se2pg_pkg::OP_POSE, 1023, 0, 32'h8000_0000, 32'h7FFF_FFFF, 16'sh7FFF,
                     -1, -1, -1, -1, -1, -1));
    add_row(make_cmd(se2pg_pkg::OP_POSE, 5, 0, 32'h0001_0000, -32'sh0002_0000, 16'sh8000,
                     0, 0, 0, 0, 0, 0));
    add_row(make_cmd(se2pg_pkg::OP_POSE, 6, 0, 32'h0003_0000, 32'h0001_8000, 16'sh4000,
                     0, 0, 0, 0, 0, 0));
    // zero information gives zero cost
    add_row(with_result(make_cmd(se2pg_pkg::OP_EDGE, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                                 16'sh7FFF, 0, 0, 0, 0, 0, 0), 0, 0, 0));
    add_row(make_cmd(se2pg_pkg::OP_EDGE, 5, 6, 32'h0001_0000, 32'h0000_8000, 16'sh4000,
                     32'h0001_0000, 32'h0000_4000, -32'sh2000, 32'h0002_0000,
                     32'h0000_1000, 32'h0001_0000));
    // angle error of exactly pi
    add_row(make_cmd(se2pg_pkg::OP_EDGE, 0, 0, 0, 0, 16'sh8000, 0, 0, 0, 0, 0,
                     32'h0001_0000));
    add_row(make_cmd(se2pg_pkg::OP_EDGE, 6, 5, 0, 0, 16'sh7FFF, 32'h0000_8000, 0, 0,
                     32'h0000_8000, 0, 32'h0004_0000));
    add_row(make_cmd(se2pg_pkg::OP_EDGE, 1023, 5, -32'sh100, 32'sh100, 16'sh0001,
                     32'h0000_0100, 0, 0, 32'h0000_0100, 0, 32'h0000_0100));
    // negative information gives a negative cost
    add_row(make_cmd(se2pg_pkg::OP_EDGE, 5, 6, 0, 0, 0, -32'sh0001_0000, 0, 0,
                     -32'sh0001_0000, 0, -32'sh0001_0000));
    add_row(with_result(make_cmd(se2pg_pkg::OP_CLEAR, 1023, 1023, -1, -1, -1, -1, -1, -1,
                                 -1, -1, -1), 0, 0, 0));
    // huge error with extreme information saturates the edge and then the total
    add_row(with_result(make_cmd(se2pg_pkg::OP_EDGE, 0, 1023, 32'h7FFF_FFFF, 0, 0,
                                 32'h7FFF_FFFF, 0, 0, 0, 0, 0),
                        64'sh7FFF_FFFF_FFFF_FFFF, 64'sh7FFF_FFFF_FFFF_FFFF, 1));
    add_row(with_result(make_cmd(se2pg_pkg::OP_EDGE, 0, 1023, 32'h7FFF_FFFF, 0, 0,
                                 32'h7FFF_FFFF, 0, 0, 0, 0, 0),
                        64'sh7FFF_FFFF_FFFF_FFFF, 64'sh7FFF_FFFF_FFFF_FFFF, 1));
    add_row(with_result(make_cmd(se2pg_pkg::OP_NONE, 1023, 1023, -1, -1, -1, -1, -1, -1,
                                 -1, -1, -1), 0, 64'sh7FFF_FFFF_FFFF_FFFF, 0));
    add_row(with_result(make_cmd(se2pg_pkg::OP_EDGE, 0, 1023, 32'h7FFF_FFFF, 0, 0,
                                 32'h8000_0000, 0, 0, 0, 0, 0),
                        64'sh8000_0000_0000_0000, -64'sd1, 1));
    add_row(with_result(make_cmd(se2pg_pkg::OP_EDGE, 0, 1023, 32'h7FFF_FFFF, 0, 0,
                                 32'h8000_0000, 0, 0, 0, 0, 0),
                        64'sh8000_0000_0000_0000, 64'sh8000_0000_0000_0000, 1));
    add_row(with_result(make_cmd(se2pg_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                        0, 0, 0));

    running_total = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) issue(directed[i]);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 2) begin
        // let the block drain completely once
        @(negedge clk_i);
        start_i = 1'b0;
        while (pending_costs.size() != 0) @(negedge clk_i);
      end
      if (n < NUM_RANDOM - CALM_TAIL && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 18));
      issue(random_cmd());
    end
    @(negedge clk_i);
    start_i = 1'b0;

    for (int w = 0; w < 200 && pending_costs.size() != 0; w++) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending_costs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (pending_costs.size() != 0)
        $display("%0t: %0d results never arrived", $time, pending_costs.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: se2_pose_graph_edge_cost.f
rtl/core/se2pg_pkg.sv
rtl/core/se2pg_ctrl.sv
rtl/core/se2pg_dp.sv
rtl/core/se2pg_ctrl_unused_guard.sv
rtl/core/se2_pose_graph_edge_cost.sv
test/se2_pose_graph_edge_cost_test.sv
